### hw/rtl/assert_macros.svh
// assertion macros shared by the allocator rtl
// every macro samples on clock and is disabled while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequent must hold at the same edge as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

### hw/rtl/mmfsa_pkg.sv
// types and constants of the max-min fair share allocator
// no dependencies; imported by mmfsa_ctrl, mmfsa_datapath and the top level core
`default_nettype none

package mmfsa_pkg;

   localparam int CAP_BITS          = 22;
   localparam int DEMAND_BITS       = 16;
   localparam int MAX_ITEMS_DEFAULT = 64;

   typedef struct packed {
      logic [DEMAND_BITS-1:0] demand;
      logic                   last_demand;
   } req_type;

   typedef struct packed {
      logic [DEMAND_BITS-1:0] allocation;
      logic                   last_allocation;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_CHECK,
      ST_SWEEP,
      ST_DRAIN,
      ST_DECIDE,
      ST_EMIT,
      ST_EMIT_DRAIN
   } state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic sweep_start;
      logic sweep_read;
      logic decide;
      logic finish;
      logic emit_start;
      logic emit_read;
      logic clear;
   } dp_cmd_type;

   typedef struct packed {
      logic full_next;
      logic share;
      logic search_open;
      logic last_issue;
      logic emit_last;
   } dp_status_type;

endpackage

`default_nettype wire

### hw/rtl/mmfsa_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module mmfsa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/mmfsa_ctrl.sv
// sequencer of the allocator: load, level search passes, emit
// depends on mmfsa_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module mmfsa_ctrl
   import mmfsa_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic          req_last,
   input  dp_status_type      status,
   output dp_cmd_type         cmd,
   output logic               busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               if (req_last || status.full_next) begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.share && status.search_open) begin
               cmd.sweep_start = 1'b1;
               state_in        = ST_SWEEP;
            end else begin
               cmd.finish     = status.share;
               cmd.emit_start = 1'b1;
               state_in       = ST_EMIT;
            end
         end
         ST_SWEEP: begin
            cmd.sweep_read = 1'b1;
            if (status.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last read data lands in the accumulator here
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_EMIT: begin
            cmd.emit_read = 1'b1;
            if (status.last_issue) begin
               state_in = ST_EMIT_DRAIN;
            end
         end
         ST_EMIT_DRAIN: begin
            cmd.clear = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // a batch only ends right after its marked final beat went out
   `ASSERT_IMPLIES(a_end_after_last, !$past(reset) && $fell(busy), $past(status.emit_last), "busy dropped without final beat")
   // emit and search reads are never issued together
   `ASSERT_ALWAYS(a_one_read_kind, !(cmd.sweep_read && cmd.emit_read), "two read kinds at once")

endmodule

`default_nettype wire

### hw/rtl/mmfsa_datapath.sv
// datapath of the allocator: demand store, totals, level search, allocation
// depends on mmfsa_pkg, mmfsa_ram and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module mmfsa_datapath
   import mmfsa_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [CAP_BITS-1:0] csr_write_data,
   input  req_type                  req_payload,
   input  dp_cmd_type               cmd,
   output dp_status_type            status,
   output logic                     rsp_strobe,
   output rsp_type                  rsp_payload
);

   localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);
   localparam int ADDR_BITS  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int SUM_BITS   = DEMAND_BITS + CNT_BITS;
   localparam int TOTAL_BITS = (SUM_BITS > CAP_BITS) ? SUM_BITS : CAP_BITS;

   logic [CAP_BITS-1:0]    capacity_ff;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [TOTAL_BITS-1:0]  total_ff, total_in;
   logic [DEMAND_BITS-1:0] max_ff, max_in;
   logic [DEMAND_BITS-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [TOTAL_BITS-1:0]  acc_ff, acc_in, sum_lo_ff, sum_lo_in;
   logic                   share_ff, share_in;
   logic [DEMAND_BITS-1:0] level_ff, level_in;
   logic [CAP_BITS-1:0]    leftover_ff, leftover_in;
   logic [CNT_BITS-1:0]    idx_ff, idx_in;
   logic [CNT_BITS-1:0]    above_ff, above_in;
   logic                   rd_pend_ff, emit_pend_ff, emit_last_ff;

   logic [DEMAND_BITS-1:0] rd_data;
   logic [DEMAND_BITS:0]   span;
   logic [DEMAND_BITS-1:0] clipped;
   logic [TOTAL_BITS-1:0]  cap_ext;
   logic                   last_issue;
   logic                   over_level;
   logic                   bonus;

   mmfsa_ram #(
      .WIDTH     (DEMAND_BITS),
      .DEPTH     (MAX_ITEMS),
      .ADDR_BITS (ADDR_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (count_ff[ADDR_BITS-1:0]),
      .wr_data (req_payload.demand),
      .rd_addr (idx_ff[ADDR_BITS-1:0]),
      .rd_data (rd_data)
   );

   assign cap_ext    = TOTAL_BITS'(capacity_ff);
   assign span       = {1'b0, hi_ff} - {1'b0, lo_ff} + (DEMAND_BITS+1)'(1);
   assign clipped    = (rd_data < mid_ff) ? rd_data : mid_ff;
   assign last_issue = (CNT_BITS'(idx_ff + CNT_BITS'(1)) == count_ff);
   assign over_level = share_ff && (rd_data > level_ff);
   assign bonus      = (CAP_BITS'(above_ff) < leftover_ff);

   always_comb begin
      count_in    = count_ff;
      total_in    = total_ff;
      max_in      = max_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      acc_in      = acc_ff;
      sum_lo_in   = sum_lo_ff;
      share_in    = share_ff;
      level_in    = level_ff;
      leftover_in = leftover_ff;
      idx_in      = idx_ff;
      above_in    = above_ff;

      if (cmd.load) begin
         count_in = count_ff + CNT_BITS'(1);
         total_in = total_ff + TOTAL_BITS'(req_payload.demand);
         max_in   = (req_payload.demand > max_ff) ? req_payload.demand : max_ff;
      end
      if (cmd.prep) begin
         share_in  = (cap_ext < total_ff);
         lo_in     = '0;
         hi_in     = max_ff;
         sum_lo_in = '0;
      end
      if (cmd.sweep_start) begin
         // upper middle of [lo, hi]
         mid_in = lo_ff + DEMAND_BITS'(span >> 1);
         acc_in = '0;
         idx_in = '0;
      end
      if (cmd.sweep_read || cmd.emit_read) begin
         idx_in = idx_ff + CNT_BITS'(1);
      end
      if (rd_pend_ff) begin
         acc_in = acc_ff + TOTAL_BITS'(clipped);
      end
      if (cmd.decide) begin
         if (acc_ff <= cap_ext) begin
            lo_in     = mid_ff;
            sum_lo_in = acc_ff;
         end else begin
            hi_in = mid_ff - DEMAND_BITS'(1);
         end
      end
      if (cmd.finish) begin
         level_in    = lo_ff;
         leftover_in = CAP_BITS'(cap_ext - sum_lo_ff);
      end
      if (cmd.emit_start) begin
         idx_in   = '0;
         above_in = '0;
      end
      if (emit_pend_ff && over_level) begin
         above_in = above_ff + CNT_BITS'(1);
      end
      if (cmd.clear) begin
         count_in = '0;
         total_in = '0;
         max_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         max_ff       <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         share_ff     <= 1'b0;
         level_ff     <= '0;
         leftover_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         emit_pend_ff <= 1'b0;
         emit_last_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         count_ff     <= count_in;
         total_ff     <= total_in;
         max_ff       <= max_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         share_ff     <= share_in;
         level_ff     <= level_in;
         leftover_ff  <= leftover_in;
         rd_pend_ff   <= cmd.sweep_read;
         emit_pend_ff <= cmd.emit_read;
         emit_last_ff <= cmd.emit_read && last_issue;
      end
   end

   always_ff @(posedge clock) begin
      mid_ff    <= mid_in;
      acc_ff    <= acc_in;
      sum_lo_ff <= sum_lo_in;
      idx_ff    <= idx_in;
      above_ff  <= above_in;
   end

   assign status.full_next   = (count_ff == CNT_BITS'(MAX_ITEMS - 1));
   assign status.share       = share_ff;
   assign status.search_open = (lo_ff < hi_ff);
   assign status.last_issue  = last_issue;
   assign status.emit_last   = emit_pend_ff && emit_last_ff;

   // demands above the level get the level, the first leftover ones one more
   assign rsp_strobe                  = emit_pend_ff;
   assign rsp_payload.allocation      = over_level ? (level_ff + DEMAND_BITS'(bonus)) : rd_data;
   assign rsp_payload.last_allocation = emit_last_ff;

   `ASSERT_ALWAYS(a_bounds_ordered, lo_ff <= hi_ff, "search bounds crossed")
   `ASSERT_ALWAYS(a_no_mixed_reads, !(rd_pend_ff && emit_pend_ff), "search and emit data mixed")
   `ASSERT_IMPLIES(a_last_with_strobe, emit_last_ff, emit_pend_ff, "final mark without a beat")

endmodule

`default_nettype wire

### hw/rtl/max_min_fair_share_allocator_core.sv
// top level of the max-min fair share allocator
// depends on mmfsa_pkg, mmfsa_ctrl, mmfsa_datapath
`default_nettype none

// Demands are loaded one per cycle while busy is low; a demand marked last, or
// the one that fills the MAX_ITEMS-entry store, closes the batch and raises busy.
// If capacity covers the batch sum the demands come back unchanged, otherwise a
// binary search finds the water level: one pass per step, each pass reading all
// n stored demands through the single read port of the store, with at most about
// log2 of the largest demand passes. After that the n allocations leave in
// arrival order, one per cycle, each on rsp_payload for a single cycle under
// rsp_strobe; the receiver cannot stall them. The user must write the capacity
// register through csr_ only while the block is idle; the block itself does not
// enforce this.
module max_min_fair_share_allocator_core
   import mmfsa_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  req_type                  req_payload,
   output logic                     rsp_strobe,
   output rsp_type                  rsp_payload,
   input  wire logic                csr_write_enable,
   input  wire logic [CAP_BITS-1:0] csr_write_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   mmfsa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_payload.last_demand),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   mmfsa_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_payload      (req_payload),
      .cmd              (cmd),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_payload      (rsp_payload)
   );

endmodule

`default_nettype wire
